FILE: hdl/range_rule_flow_table_top_assert.svh
// Assertion macros for the rule table checker
`ifndef RANGE_RULE_FLOW_TABLE_TOP_ASSERT_SVH
`define RANGE_RULE_FLOW_TABLE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RRFT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication with the consequent checked in the cycle after the antecedent
`define RRFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/rrft_pkg.sv
package rrft_pkg;
    localparam int RULE_DEPTH = 32;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;
    localparam logic [9:0]  MAX_ADDR = 10'd1000;
    localparam logic [15:0] HITS_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_ADD      = 2'd1;
    localparam logic [1:0] CMD_RELAY    = 2'd2;

    localparam logic [1:0] KIND_LOCAL = 2'd0;
    localparam logic [1:0] KIND_FWD   = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    localparam logic [2:0] V_NONE  = 3'd0;
    localparam logic [2:0] V_RELAY = 3'd1;
    localparam logic [2:0] V_LOCAL = 3'd2;
    localparam logic [2:0] V_DROP  = 3'd3;
    localparam logic [2:0] V_ASK   = 3'd4;

    localparam logic [1:0] REG_OWN_LOW  = 2'd0;
    localparam logic [1:0] REG_OWN_HIGH = 2'd1;
    localparam logic [1:0] REG_NBR_A    = 2'd2;
    localparam logic [1:0] REG_NBR_B    = 2'd3;

    // one queued beat between front and back
    typedef struct packed {
        logic [1:0] command;
        logic [9:0] src_addr;
        logic [9:0] dest_addr;
        logic       rule_is_drop;
        logic [2:0] rule_port;
        logic [9:0] rule_low;
        logic [9:0] rule_high;
        logic       src_ok;
        logic       fwd_ok;
    } item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [2:0]  out_port;
        logic [4:0]  rule_index;
        logic [15:0] rule_hits;
        logic        table_full;
        logic [9:0]  ask_src;
        logic [9:0]  ask_dest;
    } result_t;

    function automatic logic is_nbr(input logic [2:0] p, input logic [2:0] a,
                                    input logic [2:0] b);
        is_nbr = (p != 3'd0) && (p == a || p == b);
    endfunction
endpackage

FILE: hdl/rrft_front.sv
module rrft_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [9:0]         s_src_addr,
    input  logic [9:0]         s_dest_addr,
    input  logic               s_rule_is_drop,
    input  logic [2:0]         s_rule_port,
    input  logic [9:0]         s_rule_low,
    input  logic [9:0]         s_rule_high,
    input  logic [2:0]         nbr_a,
    input  logic [2:0]         nbr_b,
    output logic               q_valid,
    input  logic               q_ready,
    output rrft_pkg::item_t    q_item
);
    import rrft_pkg::*;

    localparam int QD = 2;
    item_t      fifo_reg [QD];
    logic [0:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      cls;
    logic       push, pop;

    // classify the incoming beat
    always_comb begin
        cls.command      = s_command;
        cls.src_addr     = s_src_addr;
        cls.dest_addr    = s_dest_addr;
        cls.rule_is_drop = s_rule_is_drop;
        cls.rule_port    = s_rule_port;
        cls.rule_low     = s_rule_low;
        cls.rule_high    = s_rule_high;
        cls.src_ok       = (s_src_addr <= MAX_ADDR);
        cls.fwd_ok       = !s_rule_is_drop && is_nbr(s_rule_port, nbr_a, nbr_b);
    end

    assign s_ready = (cnt_reg != 2'(QD));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign wp_next  = push ? wp_reg + 1'b1 : wp_reg;
    assign rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wp_reg] <= cls;
        end
    end
endmodule

FILE: hdl/rrft_back.sv
module rrft_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  rrft_pkg::item_t     q_item,
    input  logic [9:0]          own_low,
    input  logic [9:0]          own_high,
    input  logic [2:0]          nbr_a,
    input  logic [2:0]          nbr_b,
    output logic                r_valid,
    input  logic                r_ready,
    output rrft_pkg::result_t   r_data
);
    import rrft_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_BUMP  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // rule storage; entry 0 range comes from the own-range registers
    logic [9:0]  low_mem  [RULE_DEPTH];
    logic [9:0]  high_mem [RULE_DEPTH];
    logic [1:0]  kind_mem [RULE_DEPTH];
    logic [2:0]  port_mem [RULE_DEPTH];
    logic [15:0] hits_mem [RULE_DEPTH];
    logic [RULE_DEPTH-1:0] hv_reg;

    state_t     st_reg, st_next;
    item_t      it_reg;
    logic [CNT_W-1:0] used_reg, idx_reg;
    logic       found_reg;
    result_t    wrk_reg, wrk_next;
    result_t    res_reg;
    logic       rv_reg;

    logic [IDX_W-1:0] ix;
    logic [9:0]  e_lo, e_hi;
    logic [15:0] e_hits, e_inc;
    logic        at_end, m_cls, m_add;

    assign ix     = idx_reg[IDX_W-1:0];
    assign e_lo   = (ix == '0) ? own_low : low_mem[ix];
    assign e_hi   = (ix == '0) ? own_high : high_mem[ix];
    assign e_hits = hv_reg[ix] ? hits_mem[ix] : 16'd0;
    assign e_inc  = (e_hits == HITS_MAX) ? e_hits : e_hits + 16'd1;
    assign at_end = (idx_reg >= used_reg);
    assign m_cls  = (e_lo <= it_reg.dest_addr) && (it_reg.dest_addr <= e_hi);
    assign m_add  = (e_lo == it_reg.rule_low) && (e_hi == it_reg.rule_high);

    assign q_ready = (st_reg == ST_IDLE);
    assign r_valid = rv_reg;
    assign r_data  = res_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid) st_next = ST_SCAN;
            end
            ST_SCAN: begin
                priority if (it_reg.command == CMD_RELAY) st_next = ST_BUMP;
                else if (it_reg.command == CMD_CLASSIFY) begin
                    if (!it_reg.src_ok || at_end) st_next = ST_OUT;
                    else if (m_cls) st_next = ST_BUMP;
                end else if (it_reg.command == CMD_ADD) begin
                    if (at_end) st_next = found_reg ? ST_OUT : ST_WRITE;
                end else st_next = ST_OUT;
            end
            ST_BUMP:  st_next = ST_OUT;
            ST_WRITE: st_next = ST_OUT;
            ST_OUT: begin
                if (!rv_reg || r_ready) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // result build
    always_comb begin
        wrk_next = wrk_reg;
        unique case (st_reg)
            ST_IDLE: wrk_next = '0;
            ST_SCAN: begin
                if (it_reg.command == CMD_CLASSIFY && (!it_reg.src_ok || at_end)) begin
                    wrk_next.verdict  = V_ASK;
                    wrk_next.ask_src  = it_reg.src_addr;
                    wrk_next.ask_dest = it_reg.dest_addr;
                end else if (it_reg.command == CMD_ADD && !at_end && m_add
                             && !found_reg) begin
                    wrk_next.rule_index = ix;
                    wrk_next.rule_hits  = e_inc;
                end
                if (it_reg.command == CMD_ADD && it_reg.fwd_ok) begin
                    wrk_next.verdict  = V_RELAY;
                    wrk_next.out_port = it_reg.rule_port;
                end
            end
            ST_BUMP: begin
                wrk_next.rule_index = ix;
                wrk_next.rule_hits  = e_inc;
                if (it_reg.command == CMD_RELAY || kind_mem[ix] == KIND_LOCAL || ix == '0)
                    wrk_next.verdict = V_LOCAL;
                else if (kind_mem[ix] == KIND_FWD && is_nbr(port_mem[ix], nbr_a, nbr_b)) begin
                    wrk_next.verdict  = V_RELAY;
                    wrk_next.out_port = port_mem[ix];
                end else wrk_next.verdict = V_DROP;
            end
            ST_WRITE: begin
                if (used_reg < CNT_W'(RULE_DEPTH)) begin
                    wrk_next.rule_index = used_reg[IDX_W-1:0];
                    wrk_next.rule_hits  = 16'd1;
                end else wrk_next.table_full = 1'b1;
            end
            ST_OUT: wrk_next = wrk_reg;
            default: wrk_next = wrk_reg;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            used_reg  <= CNT_W'(1);
            hv_reg    <= '0;
            rv_reg    <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_IDLE && q_valid) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (st_reg == ST_SCAN) begin
                if (it_reg.command == CMD_ADD && !at_end) begin
                    if (m_add) begin
                        found_reg  <= 1'b1;
                        hv_reg[ix] <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end else if (it_reg.command == CMD_CLASSIFY && !at_end && !m_cls)
                    idx_reg <= idx_reg + 1'b1;
            end
            if (st_reg == ST_BUMP) hv_reg[ix] <= 1'b1;
            if (st_reg == ST_WRITE && used_reg < CNT_W'(RULE_DEPTH)) begin
                used_reg             <= used_reg + 1'b1;
                hv_reg[used_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (st_reg == ST_OUT && (!rv_reg || r_ready)) rv_reg <= 1'b1;
            else if (rv_reg && r_ready) rv_reg <= 1'b0;
        end
    end

    // payload and table writes; the output beat only loads once the last one left
    always_ff @(posedge aclk) begin
        wrk_reg <= wrk_next;
        if (st_reg == ST_OUT && (!rv_reg || r_ready)) res_reg <= wrk_reg;
        if (st_reg == ST_IDLE && q_valid) it_reg <= q_item;
        if (st_reg == ST_SCAN && it_reg.command == CMD_ADD && !at_end && m_add)
            hits_mem[ix] <= e_inc;
        if (st_reg == ST_BUMP) hits_mem[ix] <= e_inc;
        if (st_reg == ST_WRITE && used_reg < CNT_W'(RULE_DEPTH)) begin
            low_mem[used_reg[IDX_W-1:0]]  <= it_reg.rule_low;
            high_mem[used_reg[IDX_W-1:0]] <= it_reg.rule_high;
            kind_mem[used_reg[IDX_W-1:0]] <= it_reg.rule_is_drop ? KIND_DROP : KIND_FWD;
            port_mem[used_reg[IDX_W-1:0]] <= it_reg.rule_port;
            hits_mem[used_reg[IDX_W-1:0]] <= 16'd1;
        end
    end
endmodule

FILE: hdl/range_rule_flow_table_top.sv
// Each item leaves the queue in IDLE; SCAN walks the table entry by entry (a
// classify stops at the first match), then BUMP counts a hit or WRITE adds
// a rule where needed, and OUT loads the result beat; relay-in goes from SCAN
// straight to BUMP. The back end takes the next item only once back in IDLE.
// A two-entry queue lets the front accept beats while the back is busy.
// Reset (aresetn low, synchronous): config regs 0, table holds entry 0 only.
module range_rule_flow_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [9:0]  s_src_addr,
    input  logic [9:0]  s_dest_addr,
    input  logic        s_rule_is_drop,
    input  logic [2:0]  s_rule_port,
    input  logic [9:0]  s_rule_low,
    input  logic [9:0]  s_rule_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [2:0]  m_out_port,
    output logic [4:0]  m_rule_index,
    output logic [15:0] m_rule_hits,
    output logic        m_table_full,
    output logic [9:0]  m_ask_src,
    output logic [9:0]  m_ask_dest
);
    import rrft_pkg::*;

    logic [9:0] own_low_reg, own_high_reg;
    logic [2:0] nbr_a_reg, nbr_b_reg;
    logic       q_valid, q_ready;
    item_t      q_item;
    result_t    r_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_low_reg  <= '0;
            own_high_reg <= '0;
            nbr_a_reg    <= '0;
            nbr_b_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OWN_LOW:  own_low_reg  <= cfg_data;
                REG_OWN_HIGH: own_high_reg <= cfg_data;
                REG_NBR_A:    nbr_a_reg    <= cfg_data[2:0];
                REG_NBR_B:    nbr_b_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    rrft_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_src_addr, .s_dest_addr,
        .s_rule_is_drop, .s_rule_port, .s_rule_low, .s_rule_high,
        .nbr_a(nbr_a_reg), .nbr_b(nbr_b_reg), .q_valid, .q_ready, .q_item
    );

    rrft_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .own_low(own_low_reg), .own_high(own_high_reg),
        .nbr_a(nbr_a_reg), .nbr_b(nbr_b_reg),
        .r_valid(m_valid), .r_ready(m_ready), .r_data
    );

    assign m_verdict    = r_data.verdict;
    assign m_out_port   = r_data.out_port;
    assign m_rule_index = r_data.rule_index;
    assign m_rule_hits  = r_data.rule_hits;
    assign m_table_full = r_data.table_full;
    assign m_ask_src    = r_data.ask_src;
    assign m_ask_dest   = r_data.ask_dest;
endmodule

FILE: hdl/rrft_checker.sv
`include "range_rule_flow_table_top_assert.svh"
module rrft_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_verdict,
    input logic [2:0]  m_out_port,
    input logic [15:0] m_rule_hits,
    input logic        m_table_full
);
    import rrft_pkg::*;

    // stalled result beat holds
    `RRFT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_verdict))
    // relay always names a port
    `RRFT_ASSERT_IMP(a_port, aclk, aresetn, m_valid && m_verdict == V_RELAY, m_out_port != 3'd0)
    // local delivery always counts a hit
    `RRFT_ASSERT_IMP(a_local, aclk, aresetn, m_valid && m_verdict == V_LOCAL, m_rule_hits != 16'd0)
    // full flag only on a full add, never with an ask
    `RRFT_ASSERT_IMP(a_full, aclk, aresetn, m_valid && m_table_full,
        m_rule_hits == 16'd0 && m_verdict != V_ASK)
endmodule

bind range_rule_flow_table_top rrft_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_verdict, .m_out_port,
    .m_rule_hits, .m_table_full
);
